FILE: hdl/differential_drive_odometry_assert.svh
// Assertion macros for the differential drive odometry block.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DDO_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("odometry assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DDO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("odometry assertion failed");

`endif

FILE: hdl/ddo_pkg.sv
// Shared types, constants and tables for the differential drive odometry block.
`default_nettype none

package ddo_pkg;

	localparam int unsigned DDO_CORDIC_STAGES = 24;
	localparam int unsigned ITER_W = 5;
	localparam int unsigned MUL_W = 33;
	localparam int unsigned CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_DIST = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TURN = CFG_IDX_W'(1);

	localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

	typedef struct packed {
		logic signed [31:0] left_count;
		logic signed [31:0] right_count;
	} count_t;

	typedef struct packed {
		logic signed [47:0] pos_x;
		logic signed [47:0] pos_y;
		logic [31:0] heading;
	} pose_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_LEFT,
		MUL_RIGHT,
		MUL_TURN,
		MUL_COS_HI,
		MUL_COS_LO,
		MUL_SIN_HI,
		MUL_SIN_LO
	} mul_op_t;

	typedef struct packed {
		logic load_in;
		mul_op_t mul_op;
		logic lm_en;
		logic sum_en;
		logic head_en;
		logic rot_en;
		logic latch_en;
		logic part_en;
		logic x_add;
		logic y_add;
		logic out_en;
		logic [ITER_W-1:0] iter;
	} ctrl_cmd_t;

	// atan(2^-k) in units of 2^-32 turn
	function automatic logic [29:0] atan_turn(input logic [ITER_W-1:0] k);
		logic [29:0] r;
		unique case (k)
			5'd0: r = 30'd536870912;
			5'd1: r = 30'd316933406;
			5'd2: r = 30'd167458907;
			5'd3: r = 30'd85004756;
			5'd4: r = 30'd42667331;
			5'd5: r = 30'd21354465;
			5'd6: r = 30'd10679838;
			5'd7: r = 30'd5340245;
			5'd8: r = 30'd2670163;
			5'd9: r = 30'd1335087;
			5'd10: r = 30'd667544;
			5'd11: r = 30'd333772;
			5'd12: r = 30'd166886;
			5'd13: r = 30'd83443;
			5'd14: r = 30'd41722;
			5'd15: r = 30'd20861;
			5'd16: r = 30'd10430;
			5'd17: r = 30'd5215;
			5'd18: r = 30'd2608;
			5'd19: r = 30'd1304;
			5'd20: r = 30'd652;
			5'd21: r = 30'd326;
			5'd22: r = 30'd163;
			5'd23: r = 30'd81;
			5'd24: r = 30'd41;
			5'd25: r = 30'd20;
			5'd26: r = 30'd10;
			5'd27: r = 30'd5;
			5'd28: r = 30'd3;
			5'd29: r = 30'd1;
			5'd30: r = 30'd1;
			5'd31: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/ddo_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle while step is high, with quadrant fold.
`default_nettype none

module ddo_cordic import ddo_pkg::*; (
	input  logic clk,
	input  logic init,
	input  logic [31:0] angle,
	input  logic step,
	input  logic [ITER_W-1:0] iter,
	output logic signed [MUL_W-1:0] cos_v,
	output logic signed [MUL_W-1:0] sin_v
);

	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [33:0] z_q;
	logic neg_q;

	logic signed [33:0] xs;
	logic signed [33:0] ys;
	logic signed [33:0] at;
	logic signed [33:0] xn;
	logic signed [33:0] yn;

	assign xs = x_q >>> iter;
	assign ys = y_q >>> iter;
	assign at = {4'b0, atan_turn(iter)};
	assign xn = -x_q;
	assign yn = -y_q;

	assign cos_v = neg_q ? xn[MUL_W-1:0] : x_q[MUL_W-1:0];
	assign sin_v = neg_q ? yn[MUL_W-1:0] : y_q[MUL_W-1:0];

	// fold into [-1/4, 1/4) turn: bit 31 takes the value of bit 30
	always_ff @(posedge clk) begin
		if (init) begin
			x_q <= CORDIC_START;
			y_q <= '0;
			z_q <= {{3{angle[30]}}, angle[30:0]};
			neg_q <= angle[31] ^ angle[30];
		end else if (step) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/ddo_ctrl.sv
// Sequencing state machine for the odometry update.
`default_nettype none

module ddo_ctrl import ddo_pkg::*; #(
	parameter int unsigned CORDIC_STAGES = DDO_CORDIC_STAGES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic count_valid,
	output logic count_stall,
	output logic pose_valid,
	input  logic pose_stall,
	output ctrl_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_L,
		S_MUL_R,
		S_SUM,
		S_MUL_H,
		S_HEAD,
		S_ROT,
		S_LATCH,
		S_XH,
		S_XL,
		S_XA,
		S_YH,
		S_YL,
		S_YA,
		S_DONE
	} state_t;

	state_t state_q;
	logic [ITER_W-1:0] iter_q;
	logic busy_q;
	logic pose_valid_q;
	logic rot_last;
	logic out_free;

	assign rot_last = (iter_q == ITER_W'(CORDIC_STAGES - 1));
	assign out_free = !pose_valid_q || !pose_stall;
	assign count_stall = busy_q;
	assign pose_valid = pose_valid_q;

	always_comb begin
		cmd = '0;
		cmd.mul_op = MUL_NONE;
		cmd.iter = iter_q;
		unique case (state_q)
			S_IDLE: cmd.load_in = count_valid && !busy_q;
			S_MUL_L: cmd.mul_op = MUL_LEFT;
			S_MUL_R: begin
				cmd.mul_op = MUL_RIGHT;
				cmd.lm_en = 1'b1;
			end
			S_SUM: cmd.sum_en = 1'b1;
			S_MUL_H: cmd.mul_op = MUL_TURN;
			S_HEAD: cmd.head_en = 1'b1;
			S_ROT: cmd.rot_en = 1'b1;
			S_LATCH: cmd.latch_en = 1'b1;
			S_XH: cmd.mul_op = MUL_COS_HI;
			S_XL: begin
				cmd.mul_op = MUL_COS_LO;
				cmd.part_en = 1'b1;
			end
			S_XA: cmd.x_add = 1'b1;
			S_YH: cmd.mul_op = MUL_SIN_HI;
			S_YL: begin
				cmd.mul_op = MUL_SIN_LO;
				cmd.part_en = 1'b1;
			end
			S_YA: cmd.y_add = 1'b1;
			S_DONE: cmd.out_en = out_free;
			default: cmd.load_in = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q <= '0;
			busy_q <= 1'b0;
			pose_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				pose_valid_q <= 1'b1;
			end else if (pose_valid_q && !pose_stall) begin
				pose_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (count_valid && !busy_q) begin
						busy_q <= 1'b1;
						state_q <= S_MUL_L;
					end
				end
				S_MUL_L: state_q <= S_MUL_R;
				S_MUL_R: state_q <= S_SUM;
				S_SUM: state_q <= S_MUL_H;
				S_MUL_H: state_q <= S_HEAD;
				S_HEAD: begin
					iter_q <= '0;
					state_q <= S_ROT;
				end
				S_ROT: begin
					iter_q <= iter_q + 1'b1;
					if (rot_last) begin
						state_q <= S_LATCH;
					end
				end
				S_LATCH: state_q <= S_XH;
				S_XH: state_q <= S_XL;
				S_XL: state_q <= S_XA;
				S_XA: state_q <= S_YH;
				S_YH: state_q <= S_YL;
				S_YL: state_q <= S_YA;
				S_YA: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						busy_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hdl/ddo_dp.sv
// Odometry datapath: registers, shared multiplier, pose accumulators, output register.
`default_nettype none

module ddo_dp import ddo_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  ctrl_cmd_t cmd,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  count_t count,
	output pose_t pose
);

	logic [23:0] dpt_q;
	logic [31:0] tpc_q;
	logic [31:0] last_left_q;
	logic [31:0] last_right_q;
	logic [47:0] x_q;
	logic [47:0] y_q;
	logic [31:0] heading_q;

	logic [31:0] dl_q;
	logic [31:0] dr_q;
	logic [47:0] lm_q;
	logic [31:0] diff_q;
	logic [47:0] mean_q;
	logic signed [MUL_W-1:0] c_q;
	logic signed [MUL_W-1:0] s_q;
	logic [47:0] ah_q;
	logic [5:0] al_q;
	logic signed [65:0] p_q;
	pose_t pose_q;

	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	logic signed [65:0] prod;
	logic [47:0] rm;
	logic [48:0] sum49;
	logic [31:0] new_heading;
	logic [59:0] lo_sum;
	logic [47:0] term;
	logic [47:0] incr;
	logic signed [MUL_W-1:0] cos_v;
	logic signed [MUL_W-1:0] sin_v;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul_op)
			MUL_NONE: mul_a = '0;
			MUL_LEFT: begin
				mul_a = {dl_q[31], dl_q};
				mul_b = {9'b0, dpt_q};
			end
			MUL_RIGHT: begin
				mul_a = {dr_q[31], dr_q};
				mul_b = {9'b0, dpt_q};
			end
			MUL_TURN: begin
				mul_a = {diff_q[31], diff_q};
				mul_b = {1'b0, tpc_q};
			end
			MUL_COS_HI: begin
				mul_a = c_q;
				mul_b = {{9{mean_q[47]}}, mean_q[47:24]};
			end
			MUL_COS_LO: begin
				mul_a = c_q;
				mul_b = {9'b0, mean_q[23:0]};
			end
			MUL_SIN_HI: begin
				mul_a = s_q;
				mul_b = {{9{mean_q[47]}}, mean_q[47:24]};
			end
			MUL_SIN_LO: begin
				mul_a = s_q;
				mul_b = {9'b0, mean_q[23:0]};
			end
			default: mul_a = '0;
		endcase
	end

	assign prod = mul_a * mul_b;
	assign rm = p_q[55:8];
	assign sum49 = {rm[47], rm} + {lm_q[47], lm_q};
	assign new_heading = heading_q + p_q[31:0];
	// floor(c * mean / 2^30) mod 2^48 from the high and low partial products
	assign lo_sum = p_q[59:0] + {30'b0, al_q, 24'b0};
	assign term = {{18{lo_sum[59]}}, lo_sum[59:30]};
	assign incr = ah_q + term;
	assign pose = pose_q;

	ddo_cordic u_cordic (
		.clk(clk),
		.init(cmd.head_en),
		.angle(new_heading),
		.step(cmd.rot_en),
		.iter(cmd.iter),
		.cos_v(cos_v),
		.sin_v(sin_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpt_q <= '0;
			tpc_q <= '0;
			last_left_q <= '0;
			last_right_q <= '0;
			x_q <= '0;
			y_q <= '0;
			heading_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_DIST) begin
					dpt_q <= cfg_data[23:0];
				end else if (cfg_index == REG_TURN) begin
					tpc_q <= cfg_data;
				end
			end
			if (cmd.load_in) begin
				last_left_q <= count.left_count;
				last_right_q <= count.right_count;
			end
			if (cmd.head_en) begin
				heading_q <= new_heading;
			end
			if (cmd.x_add) begin
				x_q <= x_q + incr;
			end
			if (cmd.y_add) begin
				y_q <= y_q + incr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			dl_q <= count.left_count - last_left_q;
			dr_q <= count.right_count - last_right_q;
		end
		if (cmd.mul_op != MUL_NONE) begin
			p_q <= prod;
		end
		if (cmd.lm_en) begin
			lm_q <= p_q[55:8];
		end
		if (cmd.sum_en) begin
			diff_q <= rm[31:0] - lm_q[31:0];
			mean_q <= sum49[48:1];
		end
		if (cmd.latch_en) begin
			c_q <= cos_v;
			s_q <= sin_v;
		end
		if (cmd.part_en) begin
			ah_q <= p_q[53:6];
			al_q <= p_q[5:0];
		end
		if (cmd.out_en) begin
			pose_q.pos_x <= x_q;
			pose_q.pos_y <= y_q;
			pose_q.heading <= heading_q;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/differential_drive_odometry.sv
// Top level of the differential drive odometry block.
// After an item is taken, the wheel products, heading update, CORDIC rotations and x and y products
// and adds run in order on the one-step-per-cycle CORDIC and the single shared multiplier; no new item
// is taken until the cycle after the pose is registered, which waits while pose_stall holds it back.
// Reset clears x, y, heading, the stored counts and both configuration registers, not the pose output.
`default_nettype none
`include "differential_drive_odometry_assert.svh"

module differential_drive_odometry import ddo_pkg::*; #(
	parameter int unsigned CORDIC_STAGES = DDO_CORDIC_STAGES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic count_valid,
	output logic count_stall,
	input  count_t count,
	output logic pose_valid,
	input  logic pose_stall,
	output pose_t pose,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);

	ctrl_cmd_t cmd;

	assign cfg_ready = 1'b1;

	ddo_ctrl #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.count_valid(count_valid),
		.count_stall(count_stall),
		.pose_valid(pose_valid),
		.pose_stall(pose_stall),
		.cmd(cmd)
	);

	ddo_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.count(count),
		.pose(pose)
	);

	`DDO_ASSERT_NEXT(a_busy_after_accept, count_valid && !count_stall, count_stall)
	`DDO_ASSERT_SAME(a_pose_after_work, $rose(pose_valid), $past(count_stall))
	`DDO_ASSERT_SAME(a_one_load_per_item, cmd.load_in, !count_stall && !cmd.out_en)

endmodule

`default_nettype wire
